FILE: src/qtpd_pkg.sv
// Shared types and constants of the quadtree path code decoder.
// Holds field widths, item kinds, digit codes and the region struct.
// No dependencies; every other file imports it.
`default_nettype none

package qtpd_pkg;

    localparam int MAX_SIDE_DEF   = 64;
    localparam int MAX_DIGITS_DEF = 6;

    localparam int COORD_W   = 7;
    localparam int CODE_W    = 14;
    localparam int PIX_W     = 6;
    localparam int KIND_W    = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;
    localparam int APB_ADDR_W = 1;
    localparam int APB_DATA_W = 32;

    localparam logic [COORD_W-1:0] SIDE_RESET = 7'd64;

    localparam logic [APB_ADDR_W-1:0] REG_IMAGE_SIDE = 1'b0;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] DIG_NW = 3'd1;
    localparam logic [2:0] DIG_NE = 3'd2;
    localparam logic [2:0] DIG_SW = 3'd3;
    localparam logic [2:0] DIG_SE = 3'd4;

    // floor(n / 5) == (n * 52429) >> 18 for every 14-bit n.
    localparam logic [15:0] RECIP_5     = 16'd52429;
    localparam int          RECIP_SHIFT = 18;

    typedef struct packed {
        logic [COORD_W-1:0] rlo;
        logic [COORD_W-1:0] rhi;
        logic [COORD_W-1:0] clo;
        logic [COORD_W-1:0] chi;
    } region_t;

    typedef struct packed {
        logic done;
        logic paint;
    } dec_status_t;

endpackage

`default_nettype wire

FILE: src/qtpd_digit_unit.sv
// Iterative path code walker: peels one base-5 digit per cycle and narrows the region.
// Uses a reciprocal multiply for the divide by five.
// Depends on qtpd_pkg.
`default_nettype none

module qtpd_digit_unit
    import qtpd_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [CODE_W-1:0]  code,
    input  wire logic [COORD_W-1:0] side,
    output region_t                 region,
    output dec_status_t             status
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    region_t             reg_reg, reg_next;

    logic [CODE_W+15:0]  prod;
    logic [CODE_W-1:0]   quot;
    logic [CODE_W-1:0]   five_q;
    logic [CODE_W-1:0]   rem;
    logic [2:0]          digit;
    logic [COORD_W:0]    rsum;
    logic [COORD_W:0]    csum;
    logic [COORD_W-1:0]  rmid;
    logic [COORD_W-1:0]  cmid;

    assign prod   = code_reg * RECIP_5;
    assign quot   = CODE_W'(prod >> RECIP_SHIFT);
    assign five_q = (quot << 2) + quot;
    assign rem    = code_reg - five_q;
    assign digit  = rem[2:0];
    assign rsum   = {1'b0, reg_reg.rlo} + {1'b0, reg_reg.rhi};
    assign csum   = {1'b0, reg_reg.clo} + {1'b0, reg_reg.chi};
    assign rmid   = rsum[COORD_W:1];
    assign cmid   = csum[COORD_W:1];

    always_comb
    begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        code_next    = code_reg;
        reg_next     = reg_reg;
        status.done  = 1'b0;
        status.paint = 1'b0;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            code_next    = code;
            reg_next.rlo = '0;
            reg_next.clo = '0;
            reg_next.rhi = side - 7'd1;
            reg_next.chi = side - 7'd1;
        end
        else if (busy_reg)
        begin
            if (code_reg == '0)
            begin
                busy_next    = 1'b0;
                status.done  = 1'b1;
                status.paint = 1'b1;
            end
            else if (cnt_reg == CNT_W'(MAX_DIGITS))
            begin
                // Code is deeper than the walker allows: nothing is painted.
                busy_next   = 1'b0;
                status.done = 1'b1;
            end
            else
            begin
                code_next = quot;
                cnt_next  = cnt_reg + 1'b1;
                unique case (digit)
                    DIG_NW:
                    begin
                        reg_next.rhi = rmid;
                        reg_next.chi = cmid;
                    end
                    DIG_NE:
                    begin
                        reg_next.rhi = rmid;
                        reg_next.clo = cmid + 7'd1;
                    end
                    DIG_SW:
                    begin
                        reg_next.rlo = rmid + 7'd1;
                        reg_next.chi = cmid;
                    end
                    DIG_SE:
                    begin
                        reg_next.rlo = rmid + 7'd1;
                        reg_next.clo = cmid + 7'd1;
                    end
                    default:
                    begin
                        // A zero digit inside a nonzero code ends the walk unpainted.
                        busy_next   = 1'b0;
                        status.done = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        reg_reg  <= reg_next;
    end

    assign region = reg_reg;

endmodule

`default_nettype wire

FILE: src/qtpd_bitmap_mem.sv
// Bitmap row memory: one write port, one registered read port, per-row valid bits.
// A clear drops all valid bits at once; an invalid row reads as all white.
// Depends on qtpd_pkg.
`default_nettype none

module qtpd_bitmap_mem
    import qtpd_pkg::*;
#(
    parameter  int MAX_SIDE = MAX_SIDE_DEF,
    localparam int AW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 clr,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [MAX_SIDE-1:0]  rd_data,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [MAX_SIDE-1:0]  wr_data
);

    logic [MAX_SIDE-1:0] mem_reg [MAX_SIDE];
    logic [MAX_SIDE-1:0] valid_reg;
    logic [MAX_SIDE-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem_reg[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/quadtree_path_code_decoder.sv
// Quadtree path code decoder: bitmap painted by base-5 quadtree path codes.
// Input items arrive on the s_ stream (kind in s_tuser), pixel reads leave on m_.
// The image side is set through a small APB register port.
// A clear transfer whitens the whole bitmap at once, with no result.
// A read transfer gives one result: the row goes to the memory read register, then the pixel to an output register.
// A fill transfer walks its code one digit per cycle in the digit unit, then paints
// the region with one read-modify-write of a bitmap row per cycle; the single row
// memory port pair sets this paint rate. An empty code paints every row.
// One item is in work at a time: s_tready is high only between items.
// Reset makes every pixel white and the side 64; the bitmap needs no sweep.
// A stalled m_ side holds the read result in place; the next item is accepted
// meanwhile, and a following read waits until the output register is free.
// The side register may be written only while no item is in work.
// Depends on qtpd_pkg, qtpd_digit_unit and qtpd_bitmap_mem.
`default_nettype none

module quadtree_path_code_decoder
    import qtpd_pkg::*;
#(
    parameter int MAX_SIDE   = MAX_SIDE_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // s_tdata: path_code[13:0], pixel_row[19:14], pixel_col[25:20], zero fill
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[1:0]
    input  wire logic [KIND_W-1:0]     s_tuser,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // m_tdata: pixel_black[0], zero fill
    output logic      [M_TDATA_W-1:0]  m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_PAINT  = 2'd2;
    localparam logic [1:0] S_READ   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [COORD_W-1:0]   side_reg;
    logic [COORD_W-1:0]   eff_side;

    logic                 accept;
    logic [CODE_W-1:0]    in_code;
    logic [PIX_W-1:0]     in_row;
    logic [PIX_W-1:0]     in_col;
    logic                 in_bounds;

    logic [PIX_W-1:0]     rd_col_reg, rd_col_next;
    logic                 rd_inb_reg, rd_inb_next;
    logic [COORD_W-1:0]   row_reg, row_next;
    logic [COORD_W-1:0]   rhi_reg, rhi_next;
    logic [MAX_SIDE-1:0]  mask_reg, mask_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [AW-1:0]        wr_row_reg, wr_row_next;
    logic                 issuing;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 pix_reg, pix_next;

    logic                 dec_start;
    region_t              dec_region;
    dec_status_t          dec_status;

    logic                 mem_clr;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [MAX_SIDE-1:0]  mem_rd_data;
    logic                 mem_wr_en;
    logic [MAX_SIDE-1:0]  mem_wr_data;

    // Side 0 behaves as 1, anything above the storage behaves as the storage size.
    always_comb
    begin
        if (side_reg == '0)
        begin
            eff_side = 7'd1;
        end
        else if (side_reg > COORD_W'(MAX_SIDE))
        begin
            eff_side = COORD_W'(MAX_SIDE);
        end
        else
        begin
            eff_side = side_reg;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_code   = s_tdata[13:0];
    assign in_row    = s_tdata[19:14];
    assign in_col    = s_tdata[25:20];
    assign in_bounds = ({1'b0, in_row} < eff_side) && ({1'b0, in_col} < eff_side);
    assign issuing   = (row_reg <= rhi_reg);

    always_comb
    begin
        state_next    = state_reg;
        rd_col_next   = rd_col_reg;
        rd_inb_next   = rd_inb_reg;
        row_next      = row_reg;
        rhi_next      = rhi_reg;
        mask_next     = mask_reg;
        wr_pend_next  = 1'b0;
        wr_row_next   = wr_row_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        pix_next      = pix_reg;
        dec_start     = 1'b0;
        mem_clr       = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = in_row[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (s_tuser == KIND_CLEAR)
                    begin
                        mem_clr = 1'b1;
                    end
                    else if (s_tuser == KIND_FILL)
                    begin
                        dec_start  = 1'b1;
                        state_next = S_DECODE;
                    end
                    else if (s_tuser == KIND_READ)
                    begin
                        mem_rd_en   = 1'b1;
                        rd_col_next = in_col;
                        rd_inb_next = in_bounds;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DECODE:
            begin
                if (dec_status.done)
                begin
                    if (dec_status.paint && (dec_region.rlo <= dec_region.rhi)
                        && (dec_region.clo <= dec_region.chi))
                    begin
                        row_next   = dec_region.rlo;
                        rhi_next   = dec_region.rhi;
                        for (int c = 0; c < MAX_SIDE; c++)
                        begin
                            mask_next[c] = (COORD_W'(c) >= dec_region.clo)
                                && (COORD_W'(c) <= dec_region.chi);
                        end
                        state_next = S_PAINT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PAINT:
            begin
                // Row r is read while row r-1 is written back with the mask ORed in.
                mem_rd_addr = row_reg[AW-1:0];
                if (issuing)
                begin
                    mem_rd_en    = 1'b1;
                    row_next     = row_reg + 7'd1;
                    wr_pend_next = 1'b1;
                    wr_row_next  = row_reg[AW-1:0];
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    pix_next      = rd_inb_reg && mem_rd_data[rd_col_reg[AW-1:0]];
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign mem_wr_en   = wr_pend_reg;
    assign mem_wr_data = mem_rd_data | mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wr_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            side_reg     <= SIDE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            wr_pend_reg  <= wr_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (psel && penable && pwrite && pready && (paddr == REG_IMAGE_SIDE))
            begin
                side_reg <= pwdata[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_col_reg <= rd_col_next;
        rd_inb_reg <= rd_inb_next;
        row_reg    <= row_next;
        rhi_reg    <= rhi_next;
        mask_reg   <= mask_next;
        wr_row_reg <= wr_row_next;
        pix_reg    <= pix_next;
    end

    assign pready   = 1'b1;
    assign prdata   = (paddr == REG_IMAGE_SIDE) ? APB_DATA_W'(side_reg) : '0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(pix_reg);

    qtpd_digit_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dec_start),
        .code   (in_code),
        .side   (eff_side),
        .region (dec_region),
        .status (dec_status)
    );

    qtpd_bitmap_mem #(
        .MAX_SIDE (MAX_SIDE)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_row_reg),
        .wr_data (mem_wr_data)
    );

    a_write_only_in_paint: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_PAINT))
        else $error("row write outside of a paint pass");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (wr_row_reg == $past(mem_rd_addr)))
        else $error("written row differs from the row read one cycle before");

    a_paint_inside_image: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PAINT) && issuing) |-> (row_reg < eff_side))
        else $error("paint pass reached a row outside the image");

    a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_READ) && (state_next == S_IDLE)) |=> m_tvalid_reg)
        else $error("finished read left no result in the output register");

endmodule

`default_nettype wire

FILE: verif/qtpd_checker.sv
// Checker for the quadtree path code decoder: watches the item stream, the pixel
// result stream and the APB writes, keeps its own bitmap and compares every read.
// Depends on qtpd_pkg for widths, item kinds, digit codes and the register index.
module qtpd_checker
    import qtpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [KIND_W-1:0]     s_tuser,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic                  pready,
    output int                         fail_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID  = 64;
    localparam int DEPTH = 6;

    // Layout of s_tdata, lowest field last.
    typedef struct packed {
        logic [5:0]        fill;
        logic [PIX_W-1:0]  col;
        logic [PIX_W-1:0]  row;
        logic [CODE_W-1:0] code;
    } item_t;

    logic [GRID-1:0]    pixels [GRID];
    logic [COORD_W-1:0] side_reg;
    bit                 expected_black [$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int unsigned active_side();
        if (side_reg == 0)
            return 1;
        if (side_reg > GRID)
            return GRID;
        return side_reg;
    endfunction

    function automatic void paint_path(input logic [CODE_W-1:0] code_in);
        int unsigned   rest;
        int unsigned   rlo;
        int unsigned   rhi;
        int unsigned   clo;
        int unsigned   chi;
        int unsigned   rmid;
        int unsigned   cmid;
        int unsigned   n;
        logic [2:0]    digit;
        logic [GRID-1:0] cols;
        rest = code_in;
        rlo  = 0;
        clo  = 0;
        rhi  = active_side() - 1;
        chi  = rhi;
        n    = 0;
        while (n < DEPTH && rest != 0)
        begin
            digit = 3'(rest % 5);
            rest  = rest / 5;
            rmid  = (rlo + rhi) / 2;
            cmid  = (clo + chi) / 2;
            case (digit)
                DIG_NW:
                begin
                    rhi = rmid;
                    chi = cmid;
                end
                DIG_NE:
                begin
                    rhi = rmid;
                    clo = cmid + 1;
                end
                DIG_SW:
                begin
                    rlo = rmid + 1;
                    chi = cmid;
                end
                DIG_SE:
                begin
                    rlo = rmid + 1;
                    clo = cmid + 1;
                end
                default: return;
            endcase
            n++;
        end
        // A code that is still nonzero after the last level paints nothing.
        if (rest != 0)
            return;
        cols = '0;
        for (int unsigned c = clo; c <= chi && c < GRID; c++)
            cols[c] = 1'b1;
        for (int unsigned r = rlo; r <= rhi && r < GRID; r++)
            pixels[r] |= cols;
    endfunction

    function automatic void apply_item(input item_t item, input logic [KIND_W-1:0] kind);
        bit black;
        case (kind)
            KIND_CLEAR:
            begin
                for (int r = 0; r < GRID; r++)
                    pixels[r] = '0;
            end
            KIND_FILL: paint_path(item.code);
            KIND_READ:
            begin
                black = 1'b0;
                if (item.row < active_side() && item.col < active_side())
                    black = pixels[item.row][item.col];
                expected_black.insert(expected_black.size(), black);
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            for (int r = 0; r < GRID; r++)
                pixels[r] = '0;
            side_reg   = SIDE_RESET;
            fail_count = 0;
            expected_black.delete();
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_black.size() == 0)
                    report_mismatch("pixel result transfer with no read waiting");
                else
                begin
                    want = expected_black.pop_front();
                    if (m_tdata[0] !== want)
                        report_mismatch($sformatf("pixel_black is %b, predicted %b",
                                                  m_tdata[0], want));
                    if (m_tdata[M_TDATA_W-1:1] !== '0)
                        report_mismatch($sformatf("m_tdata fill bits are %b",
                                                  m_tdata[M_TDATA_W-1:1]));
                end
            end
            if (psel && penable && pwrite && pready && paddr == REG_IMAGE_SIDE)
                side_reg = pwdata[COORD_W-1:0];
            if (s_tvalid && s_tready)
                apply_item(item_t'(s_tdata), s_tuser);
            pending = expected_black.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
// Top of the quadtree path code decoder testbench: clock, reset, item stimulus,
// result back-pressure and APB side writes; the verdict comes from qtpd_checker.
// Depends on qtpd_pkg, qtpd_checker and the quadtree_path_code_decoder RTL.
module tb_top
    import qtpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT        = 500000;
    localparam int SETTLE       = 100;
    localparam int PHASE_ITEMS  = 87;
    localparam int PAUSE_AT     = 40;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int  fail_count;
    int  pending;
    int  cycles;
    bit  tx_idle;
    bit  rx_idle;
    int  cur_side;

    quadtree_path_code_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    qtpd_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("quadtree_path_code_decoder: mismatch");
            $finish;
        end
    end

    // Result side: a random stall before each transfer when rx_idle is set.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Leaves s_tvalid high when the next item follows with no gap.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                             input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, col, row, code};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained(input bit settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // A fill may still be painting after the last read result has left.
        if (settle)
            repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_side(input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_IMAGE_SIDE;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Builds a base-5 path of the given depth; with a hole, one digit that is not
    // the most significant one is zero.
    function automatic logic [CODE_W-1:0] build_path(input int depth, input bit with_hole);
        int unsigned code;
        int unsigned place;
        int unsigned digit;
        int          hole;
        code  = 0;
        place = 1;
        hole  = (with_hole && depth > 1) ? $urandom_range(0, depth - 2) : -1;
        for (int i = 0; i < depth; i++)
        begin
            digit = (i == hole) ? 0 : $urandom_range(1, 4);
            code  += digit * place;
            place *= 5;
        end
        return CODE_W'(code);
    endfunction

    function automatic logic [PIX_W-1:0] pick_coord();
        if ($urandom_range(0, 3) != 0)
            return PIX_W'($urandom_range(0, cur_side - 1));
        return PIX_W'($urandom_range(0, 63));
    endfunction

    task automatic send_random_item(output bit counted);
        int pick;
        int variant;
        logic [CODE_W-1:0] code;
        pick    = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 4)
            send_item(KIND_CLEAR, CODE_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
        else if (pick < 40)
        begin
            variant = $urandom_range(0, 9);
            if (variant < 7)
                code = build_path($urandom_range(1, 6), 1'b0);
            else if (variant == 7)
                code = build_path($urandom_range(2, 6), 1'b1);
            else if (variant == 8)
                code = CODE_W'($urandom_range(0, 15624));
            else
                code = ($urandom_range(0, 1) != 0) ? '0 : CODE_W'($urandom_range(15625, 16383));
            send_item(KIND_FILL, code, PIX_W'($urandom), PIX_W'($urandom));
        end
        else if (pick < 97)
            send_item(KIND_READ, CODE_W'($urandom), pick_coord(), pick_coord());
        else
        begin
            send_item(KIND_UNUSED, CODE_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
            counted = 1'b0;
        end
    endtask

    initial
    begin
        int side_plan [13];
        int sent;
        bit counted;
        logic [APB_DATA_W-1:0] junk;
        side_plan = '{1, 0, 2, 3, 127, 5, 64, 16, 33, 8, 100, 63, 7};
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_CLEAR;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= REG_IMAGE_SIDE;
        pwdata   <= '0;
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        cur_side = 64;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset side of 64.
        send_item(KIND_READ, '0, 6'd0, 6'd0);
        send_item(KIND_FILL, '0, 6'd0, 6'd0);              // empty code paints all
        send_item(KIND_READ, '0, 6'd63, 6'd63);
        send_item(KIND_READ, '0, 6'd0, 6'd63);
        send_item(KIND_CLEAR, 14'h3fff, 6'd63, 6'd63);
        send_item(KIND_READ, '0, 6'd63, 6'd63);
        send_item(KIND_FILL, 14'(DIG_NW), 6'd0, 6'd0);
        send_item(KIND_READ, '0, 6'd31, 6'd31);
        send_item(KIND_READ, '0, 6'd32, 6'd31);
        send_item(KIND_READ, '0, 6'd31, 6'd32);
        send_item(KIND_FILL, 14'(5 * DIG_SW + DIG_NE), 6'd0, 6'd0);
        send_item(KIND_READ, '0, 6'd16, 6'd32);
        send_item(KIND_READ, '0, 6'd15, 6'd32);
        send_item(KIND_FILL, 14'(25 * DIG_NW + DIG_NE), 6'd0, 6'd0);  // zero digit in the middle
        send_item(KIND_FILL, 14'(5 * DIG_NW), 6'd0, 6'd0);            // zero digit on top
        send_item(KIND_READ, '0, 6'd0, 6'd63);
        send_item(KIND_FILL, 14'd15624, 6'd0, 6'd0);       // deepest south-east pixel
        send_item(KIND_READ, '0, 6'd63, 6'd63);
        send_item(KIND_READ, '0, 6'd62, 6'd63);
        send_item(KIND_FILL, 14'd16383, 6'd63, 6'd63);
        send_item(KIND_FILL, 14'd15626, 6'd0, 6'd0);
        send_item(KIND_READ, '0, 6'd63, 6'd62);
        send_item(KIND_UNUSED, 14'h3fff, 6'd63, 6'd63);
        send_item(KIND_READ, '0, 6'd0, 6'd0);
        send_item(KIND_READ, 14'h3fff, 6'd63, 6'd0);

        foreach (side_plan[p])
        begin
            wait_drained(1'b1);
            junk = ($urandom_range(0, 2) == 0) ? APB_DATA_W'({$urandom, 7'd0}) : '0;
            write_side(junk | APB_DATA_W'(side_plan[p]));
            cur_side = (side_plan[p] == 0) ? 1 : (side_plan[p] > 64) ? 64 : side_plan[p];
            tx_idle  = ($urandom_range(0, 3) != 0);
            rx_idle  = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if (sent == PAUSE_AT)
                    wait_drained(1'b0);
                send_random_item(counted);
                if (counted)
                    sent++;
            end
        end

        wait_drained(1'b1);
        if (fail_count == 0)
            $display("quadtree_path_code_decoder: match");
        else
            $display("quadtree_path_code_decoder: mismatch");
        $finish;
    end

endmodule
